### hdl/bscb_pkg.sv
// Package for the box screen bounds classifier: request layout, configuration
// record and result codes. No dependencies.
package bscb_pkg;

  typedef enum logic [0:0] {
    OP_ROW,
    OP_BOX
  } op_e;

  typedef enum logic [1:0] {
    VIS_CULL = 2'd0,
    VIS_FULL = 2'd1,
    VIS_CLIP = 2'd2
  } vis_e;

  typedef enum logic [2:0] {
    REG_PERSP_SCALE  = 3'd0,
    REG_NEAR_DEPTH   = 3'd1,
    REG_FAR_DEPTH    = 3'd2,
    REG_CENTER_X     = 3'd3,
    REG_CENTER_Y     = 3'd4,
    REG_SCREEN_MAX   = 3'd5,
    REG_CLIP_RECT    = 3'd6,
    REG_OUTSIDE_VIEW = 3'd7
  } reg_e;

  localparam int unsigned CfgDataBits = 64;
  localparam logic [31:0] BoundInit = 32'h3FFF_FFFF;
  localparam logic [1:0] RowDepth = 2'd2;
  localparam logic [2:0] LastCorner = 3'd7;

  typedef struct packed {
    op_e                op;
    logic [1:0]         row;
    logic signed [15:0] coef_x;
    logic signed [15:0] coef_y;
    logic signed [15:0] coef_z;
    logic signed [31:0] coef_t;
    logic signed [15:0] box_xmin;
    logic signed [15:0] box_xmax;
    logic signed [15:0] box_ymin;
    logic signed [15:0] box_ymax;
    logic signed [15:0] box_zmin;
    logic signed [15:0] box_zmax;
  } req_t;

  typedef struct packed {
    logic [15:0] persp_scale;
    logic [30:0] near_depth;
    logic [30:0] far_depth;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [31:0] screen_max;
    logic [63:0] clip_rect;
    logic        outside_view;
  } cfg_t;

endpackage

### hdl/bscb_front.sv
// Front end: decodes incoming requests into queue entries.
// Depends on bscb_pkg.
module bscb_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [1:0]          row_index_i,
  input  logic signed [15:0]  coef_x_i,
  input  logic signed [15:0]  coef_y_i,
  input  logic signed [15:0]  coef_z_i,
  input  logic signed [31:0]  coef_t_i,
  input  logic signed [15:0]  box_xmin_i,
  input  logic signed [15:0]  box_xmax_i,
  input  logic signed [15:0]  box_ymin_i,
  input  logic signed [15:0]  box_ymax_i,
  input  logic signed [15:0]  box_zmin_i,
  input  logic signed [15:0]  box_zmax_i,
  input  logic                full_i,
  output logic                push_o,
  output bscb_pkg::req_t      req_o
);
  import bscb_pkg::*;

  logic dead_row;

  // A write to the fourth row has no effect and is dropped here.
  assign dead_row   = !func_i && (row_index_i == 2'd3);
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && !dead_row;

  always_comb begin
    req_o.op       = func_i ? OP_BOX : OP_ROW;
    req_o.row      = row_index_i;
    req_o.coef_x   = coef_x_i;
    req_o.coef_y   = coef_y_i;
    req_o.coef_z   = coef_z_i;
    req_o.coef_t   = coef_t_i;
    req_o.box_xmin = box_xmin_i;
    req_o.box_xmax = box_xmax_i;
    req_o.box_ymin = box_ymin_i;
    req_o.box_ymax = box_ymax_i;
    req_o.box_zmin = box_zmin_i;
    req_o.box_zmax = box_zmax_i;
  end

endmodule

### hdl/bscb_fifo.sv
// Two-entry queue between the front end and the classifier core.
// Depends on bscb_pkg.
module bscb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bscb_pkg::req_t req_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output bscb_pkg::req_t req_o
);
  import bscb_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign req_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### hdl/bscb_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Signed dividend, positive divisor. No dependencies.
module bscb_div #(
  parameter int unsigned W = 34
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] dividend_i,
  input  logic [W-1:0]        divisor_i,
  output logic                done_o,
  output logic signed [W-1:0] quot_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    rem_q;
  logic [W-1:0]  quo_q, dvs_q;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted = {rem_q[W-1:0], quo_q[W-1]};
  assign fits    = (shifted >= {1'b0, dvs_q});
  assign done_o  = done_q;
  assign quot_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
      dvs_q <= divisor_i;
      neg_q <= dividend_i[W-1];
    end else if (busy_q) begin
      rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/bscb_core.sv
// Back end: view matrix store and per-corner sequencer with a shared
// multiplier and divider. Depends on bscb_pkg and bscb_div.
module bscb_core #(
  parameter int unsigned COEF_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bscb_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  bscb_pkg::req_t q_req_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     visibility_o
);
  import bscb_pkg::*;

  localparam int unsigned PW = 16 + COEF_BITS;
  localparam int unsigned SW = ((PW > 32) ? PW : 32) + 2;
  localparam int unsigned BW = SW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_CHK, S_DIVD, S_DIVX, S_DIVY, S_NEXT, S_FIN
  } state_e;

  state_e                      state_q;
  logic signed [COEF_BITS-1:0] coef_q [3][3];
  logic signed [31:0]          trans_q [3];
  req_t                        box_q;
  logic [2:0]                  corner_q;
  logic [1:0]                  row_q, col_q, prow_q;
  logic signed [PW-1:0]        prod_q;
  logic                        pv_q;
  logic signed [SW-1:0]        acc_q [3];
  logic signed [SW-1:0]        dsc_q, sx_q;
  logic signed [BW-1:0]        xlo_q, xhi_q, ylo_q, yhi_q;
  logic                        bad_q, cull_q, res_valid_q;
  vis_e                        vis_q;
  logic                        div_start_q;
  logic signed [SW-1:0]        div_a_q;
  logic [SW-1:0]               div_b_q;
  logic                        div_done;
  logic signed [SW-1:0]        div_quot;

  logic signed [15:0]          coord;
  logic signed [PW-1:0]        prod;
  logic signed [SW-1:0]        near_s, far_s;
  logic signed [32:0]          far_t;
  logic signed [BW-1:0]        init_pos, sx_b, sy_b;
  logic signed [BW-1:0]        xl, xh, yl, yh, cxs, cys;
  logic                        res_free, clip, off_rect;
  logic [15:0]                 persp;

  bscb_div #(.W(SW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    case (col_q)
      2'd0:    coord = corner_q[0] ? box_q.box_xmax : box_q.box_xmin;
      2'd1:    coord = corner_q[1] ? box_q.box_ymax : box_q.box_ymin;
      default: coord = corner_q[2] ? box_q.box_zmax : box_q.box_zmin;
    endcase
  end

  assign prod     = coef_q[row_q][col_q] * coord;
  assign near_s   = $signed({{(SW - 31){1'b0}}, cfg_i.near_depth});
  assign far_s    = $signed({{(SW - 31){1'b0}}, cfg_i.far_depth});
  assign far_t    = $signed({2'b00, cfg_i.far_depth});
  assign init_pos = $signed({{(BW - 32){1'b0}}, BoundInit});
  assign sx_b     = BW'(sx_q);
  assign sy_b     = BW'(div_quot);
  assign persp    = (cfg_i.persp_scale == '0) ? 16'd1 : cfg_i.persp_scale;
  assign cxs      = $signed({{(BW - 16){1'b0}}, cfg_i.center_x});
  assign cys      = $signed({{(BW - 16){1'b0}}, cfg_i.center_y});
  assign xl       = xlo_q + cxs;
  assign xh       = xhi_q + cxs;
  assign yl       = ylo_q + cys;
  assign yh       = yhi_q + cys;

  always_comb begin
    clip = bad_q || (xl < 0) || (yl < 0)
        || (xh > $signed({{(BW - 16){1'b0}}, cfg_i.screen_max[15:0]}))
        || (yh > $signed({{(BW - 16){1'b0}}, cfg_i.screen_max[31:16]}));
    off_rect = (xl > $signed({{(BW - 16){1'b0}}, cfg_i.clip_rect[47:32]}))
        || (yl > $signed({{(BW - 16){1'b0}}, cfg_i.clip_rect[63:48]}))
        || (xh < $signed({{(BW - 16){1'b0}}, cfg_i.clip_rect[15:0]}))
        || (yh < $signed({{(BW - 16){1'b0}}, cfg_i.clip_rect[31:16]}));
  end

  assign res_free     = !res_valid_q || !out_stall_i;
  assign q_pop_o      = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o  = res_valid_q;
  assign visibility_o = vis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      vis_q       <= VIS_CULL;
      div_start_q <= 1'b0;
      pv_q        <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        trans_q[r] <= '0;
        for (int c = 0; c < 3; c++) begin
          coef_q[r][c] <= '0;
        end
      end
    end else begin
      div_start_q <= 1'b0;
      if (res_valid_q && !out_stall_i && (state_q != S_FIN)) begin
        res_valid_q <= 1'b0;
      end
      if (pv_q) begin
        acc_q[prow_q] <= acc_q[prow_q] + SW'(prod_q);
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            if (q_req_i.op == OP_ROW) begin
              coef_q[q_req_i.row][0] <= COEF_BITS'(q_req_i.coef_x);
              coef_q[q_req_i.row][1] <= COEF_BITS'(q_req_i.coef_y);
              coef_q[q_req_i.row][2] <= COEF_BITS'(q_req_i.coef_z);
              trans_q[q_req_i.row]   <= q_req_i.coef_t;
            end else begin
              box_q    <= q_req_i;
              bad_q    <= 1'b0;
              corner_q <= '0;
              row_q    <= '0;
              col_q    <= '0;
              xlo_q    <= init_pos;
              xhi_q    <= -init_pos;
              ylo_q    <= init_pos;
              yhi_q    <= -init_pos;
              for (int r = 0; r < 3; r++) begin
                acc_q[r] <= SW'(trans_q[r]);
              end
              if ((33'(trans_q[RowDepth]) >= far_t) && !cfg_i.outside_view) begin
                cull_q  <= 1'b1;
                state_q <= S_FIN;
              end else begin
                cull_q  <= 1'b0;
                state_q <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          prod_q <= prod;
          prow_q <= row_q;
          pv_q   <= 1'b1;
          if (col_q == 2'd2) begin
            col_q <= '0;
            if (row_q == RowDepth) begin
              state_q <= S_ADD;
            end else begin
              row_q <= row_q + 2'd1;
            end
          end else begin
            col_q <= col_q + 2'd1;
          end
        end
        S_ADD: begin
          pv_q    <= 1'b0;
          state_q <= S_CHK;
        end
        S_CHK: begin
          if ((acc_q[RowDepth] > near_s) && (acc_q[RowDepth] < far_s)) begin
            div_a_q     <= acc_q[RowDepth];
            div_b_q     <= SW'(persp);
            div_start_q <= 1'b1;
            state_q     <= S_DIVD;
          end else begin
            bad_q   <= 1'b1;
            state_q <= S_NEXT;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            if (div_quot == '0) begin
              bad_q   <= 1'b1;
              state_q <= S_NEXT;
            end else begin
              dsc_q       <= div_quot;
              div_a_q     <= acc_q[0];
              div_b_q     <= div_quot;
              div_start_q <= 1'b1;
              state_q     <= S_DIVX;
            end
          end
        end
        S_DIVX: begin
          if (div_done) begin
            sx_q        <= div_quot;
            div_a_q     <= acc_q[1];
            div_b_q     <= dsc_q;
            div_start_q <= 1'b1;
            state_q     <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            if (sx_b < xlo_q) xlo_q <= sx_b;
            if (sx_b > xhi_q) xhi_q <= sx_b;
            if (sy_b < ylo_q) ylo_q <= sy_b;
            if (sy_b > yhi_q) yhi_q <= sy_b;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (corner_q == LastCorner) begin
            state_q <= S_FIN;
          end else begin
            corner_q <= corner_q + 3'd1;
            row_q    <= '0;
            col_q    <= '0;
            for (int r = 0; r < 3; r++) begin
              acc_q[r] <= SW'(trans_q[r]);
            end
            state_q <= S_MUL;
          end
        end
        S_FIN: begin
          if (res_free) begin
            res_valid_q <= 1'b1;
            if (cull_q) begin
              vis_q <= VIS_CULL;
            end else if (clip) begin
              vis_q <= VIS_CLIP;
            end else if (off_rect) begin
              vis_q <= VIS_CULL;
            end else begin
              vis_q <= VIS_FULL;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_mul_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (row_q != 2'd3) && (col_q != 2'd3))
    else $error("matrix index out of range");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && out_stall_i) |=> (res_valid_q && $stable(vis_q)))
    else $error("result lost while stalled");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVX || state_q == S_DIVY) |-> (dsc_q != '0))
    else $error("zero scaled depth used as divisor");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q != S_DIVD) && (state_q != S_DIVX))
    else $error("request taken while divider in use");

endmodule

### hdl/box_screen_bounds_classifier.sv
// Sequence: a matrix row is written when the core takes it from the queue; a box culled early
// by the far depth check goes straight to its result; otherwise all eight corners are
// transformed and those in depth range are divided by the shared divider, which is
// S = max(16 + COEF_BITS, 32) + 2 bits wide.
// Throughput: one request at a time in the core; a two-entry queue takes requests meanwhile.
// Reset: asynchronous active low; matrix clears to zero and configuration to its defaults.
// Top level of the box screen bounds classifier: configuration registers, front end,
// request queue and core. Depends on bscb_pkg, bscb_front, bscb_fifo and bscb_core.
module box_screen_bounds_classifier #(
  parameter int unsigned COEF_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                func_i,
  input  logic [1:0]          row_index_i,
  input  logic signed [15:0]  coef_x_i,
  input  logic signed [15:0]  coef_y_i,
  input  logic signed [15:0]  coef_z_i,
  input  logic signed [31:0]  coef_t_i,
  input  logic signed [15:0]  box_xmin_i,
  input  logic signed [15:0]  box_xmax_i,
  input  logic signed [15:0]  box_ymin_i,
  input  logic signed [15:0]  box_ymax_i,
  input  logic signed [15:0]  box_zmin_i,
  input  logic signed [15:0]  box_zmax_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          visibility_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_wdata_i
);
  import bscb_pkg::*;

  cfg_t cfg_q;
  req_t front_req, q_req;
  logic push, full, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.persp_scale  <= 16'd1;
      cfg_q.near_depth   <= '0;
      cfg_q.far_depth    <= '1;
      cfg_q.center_x     <= '0;
      cfg_q.center_y     <= '0;
      cfg_q.screen_max   <= '0;
      cfg_q.clip_rect    <= '0;
      cfg_q.outside_view <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_PERSP_SCALE:  cfg_q.persp_scale  <= cfg_wdata_i[15:0];
        REG_NEAR_DEPTH:   cfg_q.near_depth   <= cfg_wdata_i[30:0];
        REG_FAR_DEPTH:    cfg_q.far_depth    <= cfg_wdata_i[30:0];
        REG_CENTER_X:     cfg_q.center_x     <= cfg_wdata_i[15:0];
        REG_CENTER_Y:     cfg_q.center_y     <= cfg_wdata_i[15:0];
        REG_SCREEN_MAX:   cfg_q.screen_max   <= cfg_wdata_i[31:0];
        REG_CLIP_RECT:    cfg_q.clip_rect    <= cfg_wdata_i[CfgDataBits-1:0];
        REG_OUTSIDE_VIEW: cfg_q.outside_view <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  bscb_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .row_index_i (row_index_i),
    .coef_x_i    (coef_x_i),
    .coef_y_i    (coef_y_i),
    .coef_z_i    (coef_z_i),
    .coef_t_i    (coef_t_i),
    .box_xmin_i  (box_xmin_i),
    .box_xmax_i  (box_xmax_i),
    .box_ymin_i  (box_ymin_i),
    .box_ymax_i  (box_ymax_i),
    .box_zmin_i  (box_zmin_i),
    .box_zmax_i  (box_zmax_i),
    .full_i      (full),
    .push_o      (push),
    .req_o       (front_req)
  );

  bscb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .req_o   (q_req)
  );

  bscb_core #(.COEF_BITS(COEF_BITS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_req_i      (q_req),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .visibility_o (visibility_o)
  );

endmodule
